### rtl/core/bpa_pkg.sv
// ----------------------------------------------------------------------------
// Buddy page allocator package
// Shared types and codes for the buddy page allocator.
// ----------------------------------------------------------------------------
package bpa_pkg;

   typedef enum logic [1:0] {
      OP_ALLOC    = 2'd0,
      OP_FREE     = 2'd1,
      OP_ALLOC_AT = 2'd2,
      OP_MAP      = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      STAT_OK       = 3'd0,
      STAT_ORDER    = 3'd1,
      STAT_OOM      = 3'd2,
      STAT_NOT_FREE = 3'd3,
      STAT_FULL     = 3'd4
   } status_type;

   // Where a release (or a bare push) returns when it completes.
   typedef enum logic [1:0] {
      RET_SPLIT = 2'd0,
      RET_FREE  = 2'd1,
      RET_AT    = 2'd2,
      RET_MAP   = 2'd3
   } ret_type;

   typedef enum logic [17:0] {
      S_IDLE         = 18'h00001,
      S_ALLOC_SEARCH = 18'h00002,
      S_ALLOC_DATA   = 18'h00004,
      S_ALLOC_SPLIT  = 18'h00008,
      S_REL_TAKE     = 18'h00010,
      S_REL_STEP     = 18'h00020,
      S_TAKE_BEGIN   = 18'h00040,
      S_TAKE_RD      = 18'h00080,
      S_TAKE_CMP     = 18'h00100,
      S_TAKE_LAST    = 18'h00200,
      S_PUSH         = 18'h00400,
      S_AT_SEARCH    = 18'h00800,
      S_AT_STEP      = 18'h01000,
      S_AT_SPLIT     = 18'h02000,
      S_MAP_CHECK    = 18'h04000,
      S_MAP_ORD      = 18'h08000,
      S_DONE         = 18'h10000,
      S_SPARE        = 18'h20000
   } state_type;

endpackage

### rtl/core/buddy_page_allocator.sv
// ----------------------------------------------------------------------------
// Buddy page allocator
// One free list per order in a shared RAM, run by a small sequencer.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Ports                                  Handshake
//   req      in         req_op, req_order, req_page            valid / stall
//   rsp      out        rsp_result_page, rsp_status            valid / stall
//   csr      in         csr_index, csr_wdata                   csr_we, no wait
//
// The block works on one item at a time and holds req_stall high from the
// item's acceptance until its result has been taken. Every search for a
// buddy or a block walks a free list entry by entry through the single RAM
// read port, reading and then comparing each entry, and each push, pop or
// swap-remove is a further step. Reset is synchronous and clears the list
// counts, so the RAM needs no clearing pass.
// A stalled result simply waits in the done state.
//
module buddy_page_allocator
   import bpa_pkg::*;
#(
   parameter int MAX_ORDER        = 11,
   parameter int ORDER0_CAPACITY  = 1024,
   parameter int PAGE_NUMBER_BITS = 20
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [1:0]                  req_op,
   input  logic [3:0]                  req_order,
   input  logic [PAGE_NUMBER_BITS-1:0] req_page,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [PAGE_NUMBER_BITS-1:0] rsp_result_page,
   output logic [2:0]                  rsp_status,
   input  logic                        csr_we,
   input  logic                        csr_index,
   input  logic [PAGE_NUMBER_BITS:0]   csr_wdata
);

   localparam int PNB   = PAGE_NUMBER_BITS;
   localparam int OW    = $clog2(MAX_ORDER + 1);
   localparam int IW    = $clog2(MAX_ORDER);
   localparam int CW    = $clog2(ORDER0_CAPACITY + 1);
   localparam int DEPTH = 2 * ORDER0_CAPACITY;
   localparam int AW    = $clog2(DEPTH);
   localparam int SW    = ((PNB > MAX_ORDER) ? PNB : MAX_ORDER) + 2;
   localparam logic [PNB:0] PAGE_LIMIT = {1'b1, {PNB{1'b0}}};

   // Start of list k in the RAM: the capacities of all lower orders.
   function automatic int base_of(input int k);
      int s;
      s = 0;
      for (int j = 0; j < k; j++) begin
         s += ORDER0_CAPACITY >> j;
      end
      return s;
   endfunction

   logic [AW-1:0] base_tab [MAX_ORDER];
   logic [CW-1:0] cap_tab  [MAX_ORDER];

   for (genvar g = 0; g < MAX_ORDER; g++) begin : g_tab
      assign base_tab[g] = AW'(base_of(g));
      assign cap_tab[g]  = CW'(ORDER0_CAPACITY >> g);
   end

   // Registers.
   state_type      state_ff, state_in;
   logic [OW-1:0]  req_ord_ff, req_ord_in;
   logic [PNB-1:0] page_ff, page_in;
   logic [PNB-1:0] res_ff, res_in;
   status_type     status_ff, status_in;
   logic           dropped_ff, dropped_in;
   logic [OW-1:0]  cur_ord_ff, cur_ord_in;
   logic [IW-1:0]  k_ff, k_in;
   logic [PNB-1:0] rel_pg_ff, rel_pg_in;
   logic [PNB-1:0] blk_ff, blk_in;
   logic [PNB-1:0] tgt_ff, tgt_in;
   logic [CW-1:0]  scan_ff, scan_in;
   logic           found_ff, found_in;
   logic           take_at_ff, take_at_in;
   ret_type        ret_ff, ret_in;
   logic [PNB:0]   map_pg_ff, map_pg_in;
   logic [PNB:0]   end_sat_ff, end_sat_in;
   logic [PNB:0]   start_reg_ff;
   logic [PNB:0]   end_reg_ff;
   logic [CW-1:0]  count_ff [MAX_ORDER];

   // Datapath signals.
   logic           mem_we;
   logic [AW-1:0]  mem_waddr;
   logic [PNB-1:0] mem_wdata;
   logic [AW-1:0]  mem_raddr;
   logic [PNB-1:0] mem_rdata;
   logic           cnt_we;
   logic [CW-1:0]  cnt_wval;
   logic [IW-1:0]  ord_idx;
   logic           ord_ok;
   logic [CW-1:0]  cnt_cur;
   logic [AW-1:0]  base_cur;
   logic [CW-1:0]  cap_cur;
   logic [PNB-1:0] ord_bit;
   logic [PNB-1:0] k_bit;
   logic [SW-1:0]  k_w;
   logic [SW-1:0]  upper_w;
   logic [IW-1:0]  k_dn;
   logic           map_fits;
   state_type      take_ret;

   bpa_ram #(
      .WIDTH (PNB),
      .DEPTH (DEPTH)
   ) u_lists (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   // The current order selects one list: its count, base and capacity.
   assign ord_idx  = cur_ord_ff[IW-1:0];
   assign ord_ok   = cur_ord_ff < OW'(MAX_ORDER);
   assign cnt_cur  = ord_ok ? count_ff[ord_idx] : '0;
   assign base_cur = base_tab[ord_idx];
   assign cap_cur  = cap_tab[ord_idx];
   assign ord_bit  = PNB'(1) << cur_ord_ff;
   assign k_bit    = PNB'(1) << k_ff;
   assign k_w      = SW'(1) << k_ff;
   assign k_dn     = k_ff - IW'(1);
   assign upper_w  = SW'(blk_ff) + (SW'(1) << k_dn);
   assign map_fits = (SW'(map_pg_ff) + k_w <= SW'(end_sat_ff)) &&
                     ((SW'(map_pg_ff) & (k_w - SW'(1))) == '0);
   assign take_ret = take_at_ff ? S_AT_STEP : S_REL_STEP;

   always_comb begin
      state_in   = state_ff;
      req_ord_in = req_ord_ff;
      page_in    = page_ff;
      res_in     = res_ff;
      status_in  = status_ff;
      dropped_in = dropped_ff;
      cur_ord_in = cur_ord_ff;
      k_in       = k_ff;
      rel_pg_in  = rel_pg_ff;
      blk_in     = blk_ff;
      tgt_in     = tgt_ff;
      scan_in    = scan_ff;
      found_in   = found_ff;
      take_at_in = take_at_ff;
      ret_in     = ret_ff;
      map_pg_in  = map_pg_ff;
      end_sat_in = end_sat_ff;
      mem_we     = 1'b0;
      mem_waddr  = '0;
      mem_wdata  = '0;
      mem_raddr  = '0;
      cnt_we     = 1'b0;
      cnt_wval   = '0;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               page_in    = req_page;
               res_in     = '0;
               status_in  = STAT_OK;
               dropped_in = 1'b0;
               case (op_type'(req_op))
                  OP_ALLOC, OP_FREE: begin
                     if ({1'b0, req_order} >= 5'(MAX_ORDER)) begin
                        status_in = STAT_ORDER;
                        state_in  = S_DONE;
                     end else begin
                        req_ord_in = OW'(req_order);
                        cur_ord_in = OW'(req_order);
                        rel_pg_in  = req_page;
                        ret_in     = RET_FREE;
                        state_in   = (op_type'(req_op) == OP_ALLOC) ?
                                     S_ALLOC_SEARCH : S_REL_TAKE;
                     end
                  end
                  OP_ALLOC_AT: begin
                     k_in     = IW'(MAX_ORDER - 1);
                     state_in = S_AT_SEARCH;
                  end
                  default: begin
                     map_pg_in  = start_reg_ff;
                     end_sat_in = (end_reg_ff > PAGE_LIMIT) ? PAGE_LIMIT : end_reg_ff;
                     state_in   = S_MAP_CHECK;
                  end
               endcase
            end
         end

         // Walk up from the requested order to the first non-empty list.
         S_ALLOC_SEARCH: begin
            if (!ord_ok) begin
               status_in = STAT_OOM;
               state_in  = S_DONE;
            end else if (cnt_cur == '0) begin
               cur_ord_in = cur_ord_ff + OW'(1);
            end else begin
               cnt_we    = 1'b1;
               cnt_wval  = cnt_cur - CW'(1);
               mem_raddr = base_cur + AW'(cnt_cur - CW'(1));
               state_in  = S_ALLOC_DATA;
            end
         end

         S_ALLOC_DATA: begin
            res_in   = mem_rdata;
            state_in = S_ALLOC_SPLIT;
         end

         // Push the upper half at each order on the way down.
         S_ALLOC_SPLIT: begin
            if (cur_ord_ff > req_ord_ff) begin
               cur_ord_in = cur_ord_ff - OW'(1);
               rel_pg_in  = res_ff + (PNB'(1) << (cur_ord_ff - OW'(1)));
               ret_in     = RET_SPLIT;
               state_in   = S_PUSH;
            end else begin
               state_in = S_DONE;
            end
         end

         // Release: try to take the buddy, merging upward while it is free.
         S_REL_TAKE: begin
            if (cur_ord_ff < OW'(MAX_ORDER - 1)) begin
               tgt_in     = rel_pg_ff ^ ord_bit;
               take_at_in = 1'b0;
               scan_in    = '0;
               state_in   = S_TAKE_BEGIN;
            end else begin
               state_in = S_PUSH;
            end
         end

         S_REL_STEP: begin
            if (found_ff) begin
               rel_pg_in  = rel_pg_ff & ~ord_bit;
               cur_ord_in = cur_ord_ff + OW'(1);
               state_in   = S_REL_TAKE;
            end else begin
               state_in = S_PUSH;
            end
         end

         // Search list cur_ord for tgt; on a hit the last entry fills the hole.
         S_TAKE_BEGIN: begin
            if (cnt_cur == '0) begin
               found_in = 1'b0;
               state_in = take_ret;
            end else begin
               state_in = S_TAKE_RD;
            end
         end

         S_TAKE_RD: begin
            mem_raddr = base_cur + AW'(scan_ff);
            state_in  = S_TAKE_CMP;
         end

         S_TAKE_CMP: begin
            if (mem_rdata == tgt_ff) begin
               mem_raddr = base_cur + AW'(cnt_cur - CW'(1));
               state_in  = S_TAKE_LAST;
            end else if (CW'(scan_ff + CW'(1)) == cnt_cur) begin
               found_in = 1'b0;
               state_in = take_ret;
            end else begin
               scan_in  = scan_ff + CW'(1);
               state_in = S_TAKE_RD;
            end
         end

         S_TAKE_LAST: begin
            mem_we    = 1'b1;
            mem_waddr = base_cur + AW'(scan_ff);
            mem_wdata = mem_rdata;
            cnt_we    = 1'b1;
            cnt_wval  = cnt_cur - CW'(1);
            found_in  = 1'b1;
            state_in  = take_ret;
         end

         S_PUSH: begin
            if (cnt_cur < cap_cur) begin
               mem_we    = 1'b1;
               mem_waddr = base_cur + AW'(cnt_cur);
               mem_wdata = rel_pg_ff;
               cnt_we    = 1'b1;
               cnt_wval  = cnt_cur + CW'(1);
            end else begin
               dropped_in = 1'b1;
            end
            case (ret_ff)
               RET_SPLIT: state_in = S_ALLOC_SPLIT;
               RET_AT:    state_in = S_AT_SPLIT;
               RET_MAP:   state_in = S_MAP_CHECK;
               default:   state_in = S_DONE;
            endcase
         end

         // Alloc-at: look for the enclosing free block, largest order first.
         S_AT_SEARCH: begin
            tgt_in     = page_ff & ~(k_bit - PNB'(1));
            cur_ord_in = OW'(k_ff);
            take_at_in = 1'b1;
            scan_in    = '0;
            state_in   = S_TAKE_BEGIN;
         end

         S_AT_STEP: begin
            if (found_ff) begin
               blk_in   = tgt_ff;
               state_in = S_AT_SPLIT;
            end else if (k_ff == '0) begin
               status_in = STAT_NOT_FREE;
               state_in  = S_DONE;
            end else begin
               k_in     = k_dn;
               state_in = S_AT_SEARCH;
            end
         end

         // Halve the block, releasing the half that does not hold the page.
         S_AT_SPLIT: begin
            if (k_ff == '0) begin
               res_in   = page_ff;
               state_in = S_DONE;
            end else begin
               k_in       = k_dn;
               cur_ord_in = OW'(k_dn);
               ret_in     = RET_AT;
               state_in   = S_REL_TAKE;
               if (SW'(page_ff) >= upper_w) begin
                  rel_pg_in = blk_ff;
                  blk_in    = PNB'(upper_w);
               end else begin
                  rel_pg_in = PNB'(upper_w);
               end
            end
         end

         S_MAP_CHECK: begin
            if (map_pg_ff < end_sat_ff) begin
               k_in     = IW'(MAX_ORDER - 1);
               state_in = S_MAP_ORD;
            end else begin
               state_in = S_DONE;
            end
         end

         // Largest aligned block that still fits below the region end.
         S_MAP_ORD: begin
            if (k_ff == '0 || map_fits) begin
               rel_pg_in  = PNB'(map_pg_ff);
               cur_ord_in = OW'(k_ff);
               map_pg_in  = (PNB + 1)'(SW'(map_pg_ff) + k_w);
               ret_in     = RET_MAP;
               state_in   = S_REL_TAKE;
            end else begin
               k_in = k_dn;
            end
         end

         S_DONE: begin
            if (!rsp_stall) begin
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         start_reg_ff <= '0;
         end_reg_ff   <= '0;
         for (int i = 0; i < MAX_ORDER; i++) begin
            count_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            if (csr_index) begin
               end_reg_ff <= csr_wdata;
            end else begin
               start_reg_ff <= csr_wdata;
            end
         end
         if (cnt_we) begin
            count_ff[ord_idx] <= cnt_wval;
         end
      end
   end

   always_ff @(posedge clock) begin
      req_ord_ff <= req_ord_in;
      page_ff    <= page_in;
      res_ff     <= res_in;
      status_ff  <= status_in;
      dropped_ff <= dropped_in;
      cur_ord_ff <= cur_ord_in;
      k_ff       <= k_in;
      rel_pg_ff  <= rel_pg_in;
      blk_ff     <= blk_in;
      tgt_ff     <= tgt_in;
      scan_ff    <= scan_in;
      found_ff   <= found_in;
      take_at_ff <= take_at_in;
      ret_ff     <= ret_in;
      map_pg_ff  <= map_pg_in;
      end_sat_ff <= end_sat_in;
   end

   assign req_stall       = (state_ff != S_IDLE);
   assign rsp_valid       = (state_ff == S_DONE);
   assign rsp_result_page = res_ff;
   // A dropped push only shows when nothing else went wrong.
   assign rsp_status      = (status_ff == STAT_OK && dropped_ff) ? STAT_FULL : status_ff;

endmodule

### rtl/core/bpa_ram.sv
// ----------------------------------------------------------------------------
// Buddy page allocator RAM
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module bpa_ram #(
   parameter int WIDTH = 20,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
